// ===== src/fbpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed-size block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // pool geometry
  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS + 1);  // 0 .. MAX_SLOTS
  localparam int unsigned IDX_W     = $clog2(MAX_SLOTS);      // 0 .. MAX_SLOTS-1

  // field widths
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned ALIGN_W   = 8;
  localparam int unsigned USED_W    = 26;
  localparam int unsigned LIVE_W    = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // null mark of the free list
  localparam logic [SLOT_W-1:0] NIL_SLOT = SLOT_W'(MAX_SLOTS);
  localparam logic [USED_W-1:0] USED_MAX = '1;
  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_MISMATCH = 3'd2,
    STAT_NULL     = 3'd3,
    STAT_BAD_ADDR = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_POOL  = 2'd1,
    CFG_SIZE  = 2'd2,
    CFG_ALIGN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] request_alignment;
    logic [ADDR_W-1:0]  block_address;
  } fbpa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] given_address;
    logic [2:0]        status;
    logic [USED_W-1:0] used_bytes;
    logic [LIVE_W-1:0] live_blocks;
  } fbpa_out_t;

endpackage
`default_nettype wire

// ===== src/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sequence: alloc reads the link and pops the head; free runs the shared radix-2 divider,
//   then checks and pushes; init runs the divider, loads the count and writes one link
//   per slot; an init of a pool with no room and words rejected at the input skip the divider
// throughput: one word in flight; a result word held by out_stall_i holds back the next
// reset: asynchronous, active low; free list empty, counters zero, object size
//   and alignment 4; link memory is not cleared (it is rebuilt by init)
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// equal-size block pool with a lifo free list of slot indices
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // request words
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire fbpa_in_t             in_data_i,
  // result words
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output fbpa_out_t                 out_data_o,
  // register writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned PROD_W = SLOT_W + SIZE_W;

  typedef enum logic [2:0] {
    ST_IDLE,      // waits for a request word
    ST_POP,       // alloc: link read back, pop the head
    ST_DIV,       // shared divider iterating
    ST_FREE_FIN,  // free: check quotient and remainder, push
    ST_LINK,      // init: load the count, then write one link per cycle
    ST_DONE       // result ready, waits for the output register
  } state_e;

  // sequencer and result registers
  state_e                  state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic [ADDR_W-1:0]       res_given_q, res_given_d;
  status_e                 res_status_q, res_status_d;
  fbpa_out_t               out_q, out_d;
  logic                    out_valid_q, out_valid_d;
  logic                    init_take_q, init_take_d;

  // configuration registers
  logic [ADDR_W-1:0]       cfg_base_q, cfg_base_d;
  logic [CFG_W-1:0]        cfg_pool_q, cfg_pool_d;
  logic [SIZE_W-1:0]       cfg_size_q, cfg_size_d;
  logic [ALIGN_W-1:0]      cfg_align_q, cfg_align_d;

  // allocator state
  logic [SLOT_W-1:0]       free_head_q, free_head_d;
  logic [SLOT_W-1:0]       slot_count_q, slot_count_d;
  logic [ALIGN_W-1:0]      adj_q, adj_d;
  logic [USED_W-1:0]       used_q, used_d;
  logic [LIVE_W-1:0]       live_q, live_d;
  logic [PROD_W-1:0]       prod_q, prod_d;
  logic [SLOT_W-1:0]       link_idx_q, link_idx_d;

  // shared divider
  logic [ADDR_W-1:0]       div_quot_q, div_quot_d;
  logic [SIZE_W-1:0]       div_rem_q, div_rem_d;
  logic [4:0]              div_cnt_q, div_cnt_d;
  logic [SIZE_W:0]         div_part;
  logic [SIZE_W:0]         div_diff;
  logic                    div_ge;

  // link memory
  logic [SLOT_W-1:0]       link_mem [MAX_SLOTS];
  logic [SLOT_W-1:0]       rd_data_q;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [SLOT_W-1:0]       mem_wdata;

  // helpers
  logic                    in_fire;
  logic [ALIGN_W-1:0]      align_m1;
  logic [ALIGN_W-1:0]      adj_calc;
  logic [ADDR_W-1:0]       first_addr;
  logic [USED_W:0]         used_sum;
  logic [SLOT_W-1:0]       cap_count;
  logic [SLOT_W-1:0]       link_next;
  logic                    out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // alignment adjust of the base, 8-bit arithmetic is enough after the mask
  assign align_m1   = cfg_align_q - 8'd1;
  assign adj_calc   = (cfg_align_q == '0) ? '0
                    : ((cfg_align_q - (cfg_base_q[ALIGN_W-1:0] & align_m1)) & align_m1);
  assign first_addr = cfg_base_q + ADDR_W'(adj_q);
  assign used_sum   = {1'b0, used_q} + (USED_W + 1)'(cfg_size_q);

  // one restoring divider step
  assign div_part = {div_rem_q, div_quot_q[ADDR_W-1]};
  assign div_diff = div_part - {1'b0, cfg_size_q};
  assign div_ge   = (div_part >= {1'b0, cfg_size_q});

  // slot count saturates at the pool limit
  assign cap_count = (div_quot_q > ADDR_W'(MAX_SLOTS)) ? NIL_SLOT
                   : div_quot_q[SLOT_W-1:0];
  assign link_next = (SLOT_W'(link_idx_q + 1'b1) < slot_count_q)
                   ? SLOT_W'(link_idx_q + 1'b1) : NIL_SLOT;

  // the quotient of an init is complete on the first link cycle
  assign init_take_d = (state_q == ST_DIV) && (div_cnt_q == '1) && (op_q == OP_INIT);

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    res_given_d  = res_given_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    cfg_base_d   = cfg_base_q;
    cfg_pool_d   = cfg_pool_q;
    cfg_size_d   = cfg_size_q;
    cfg_align_d  = cfg_align_q;
    free_head_d  = free_head_q;
    slot_count_d = slot_count_q;
    adj_d        = adj_q;
    used_d       = used_q;
    live_d       = live_q;
    prod_d       = prod_q;
    link_idx_d   = link_idx_q;
    div_quot_d   = div_quot_q;
    div_rem_d    = div_rem_q;
    div_cnt_d    = div_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = link_idx_q[IDX_W-1:0];
    mem_wdata    = link_next;

    // output register drains independently of the sequencer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // register writes, only while idle by contract
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BASE:  cfg_base_d  = cfg_data_i;
        CFG_POOL:  cfg_pool_d  = cfg_data_i;
        CFG_SIZE:  cfg_size_d  = cfg_data_i[SIZE_W-1:0];
        CFG_ALIGN: cfg_align_d = cfg_data_i[ALIGN_W-1:0];
        default:   ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d         = in_data_i.opcode;
          res_given_d  = '0;
          res_status_d = STAT_OK;
          state_d      = ST_DONE;
          unique case (in_data_i.opcode)
            OP_ALLOC: begin
              if (in_data_i.request_size != cfg_size_q ||
                  in_data_i.request_alignment != cfg_align_q) begin
                res_status_d = STAT_MISMATCH;
              end else if (free_head_q >= slot_count_q || free_head_q >= NIL_SLOT) begin
                res_status_d = STAT_EMPTY;
              end else begin
                // link read issued this cycle, offset product registered
                prod_d  = PROD_W'(free_head_q * cfg_size_q);
                state_d = ST_POP;
              end
            end
            OP_FREE: begin
              if (in_data_i.block_address == '0) begin
                res_status_d = STAT_NULL;
              end else if (slot_count_q == '0 || cfg_size_q == '0) begin
                res_status_d = STAT_BAD_ADDR;
              end else begin
                div_quot_d = in_data_i.block_address - first_addr;
                div_rem_d  = '0;
                div_cnt_d  = '0;
                state_d    = ST_DIV;
              end
            end
            OP_INIT: begin
              adj_d = adj_calc;
              if (cfg_size_q == '0 || cfg_pool_q < CFG_W'(adj_calc)) begin
                slot_count_d = '0;
                free_head_d  = NIL_SLOT;
                used_d       = '0;
                live_d       = '0;
                link_idx_d   = '0;
                state_d      = ST_LINK;
              end else begin
                div_quot_d = cfg_pool_q - CFG_W'(adj_calc);
                div_rem_d  = '0;
                div_cnt_d  = '0;
                state_d    = ST_DIV;
              end
            end
            default: begin
              res_status_d = STAT_MISMATCH;
            end
          endcase
        end
      end

      ST_POP: begin
        res_given_d = first_addr + ADDR_W'(prod_q);
        free_head_d = rd_data_q;
        used_d      = (used_sum > {1'b0, USED_MAX}) ? USED_MAX : used_sum[USED_W-1:0];
        if (live_q < LIVE_MAX) begin
          live_d = live_q + 1'b1;
        end
        state_d = ST_DONE;
      end

      ST_DIV: begin
        div_quot_d = {div_quot_q[ADDR_W-2:0], div_ge};
        div_rem_d  = div_ge ? div_diff[SIZE_W-1:0] : div_part[SIZE_W-1:0];
        div_cnt_d  = div_cnt_q + 1'b1;
        if (div_cnt_q == '1) begin
          state_d = (op_q == OP_INIT) ? ST_LINK : ST_FREE_FIN;
        end
        if (div_cnt_q == '1 && op_q == OP_INIT) begin
          // quotient is complete only next cycle, so the count is taken in ST_LINK
          link_idx_d = '0;
        end
      end

      ST_FREE_FIN: begin
        if (div_rem_q != '0 || div_quot_q >= ADDR_W'(slot_count_q)) begin
          res_status_d = STAT_BAD_ADDR;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = div_quot_q[IDX_W-1:0];
          mem_wdata   = free_head_q;
          free_head_d = div_quot_q[SLOT_W-1:0];
          used_d      = (used_q > USED_W'(cfg_size_q)) ? used_q - USED_W'(cfg_size_q) : '0;
          if (live_q > '0) begin
            live_d = live_q - 1'b1;
          end
        end
        state_d = ST_DONE;
      end

      ST_LINK: begin
        if (init_take_q) begin
          // load the capped slot count and restart the list, the sweep follows
          slot_count_d = cap_count;
          free_head_d  = (cap_count != '0) ? '0 : NIL_SLOT;
          used_d       = '0;
          live_d       = '0;
          link_idx_d   = '0;
        end else if (link_idx_q < slot_count_q) begin
          mem_we     = 1'b1;
          link_idx_d = link_idx_q + 1'b1;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_d.given_address = res_given_q;
          out_d.status        = res_status_q;
          out_d.used_bytes    = used_q;
          out_d.live_blocks   = live_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_ALLOC;
      res_given_q  <= '0;
      res_status_q <= STAT_OK;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      cfg_base_q   <= '0;
      cfg_pool_q   <= '0;
      cfg_size_q   <= SIZE_W'(4);
      cfg_align_q  <= ALIGN_W'(4);
      free_head_q  <= NIL_SLOT;
      slot_count_q <= '0;
      adj_q        <= '0;
      used_q       <= '0;
      live_q       <= '0;
      prod_q       <= '0;
      link_idx_q   <= '0;
      div_quot_q   <= '0;
      div_rem_q    <= '0;
      div_cnt_q    <= '0;
      init_take_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      res_given_q  <= res_given_d;
      res_status_q <= res_status_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
      cfg_base_q   <= cfg_base_d;
      cfg_pool_q   <= cfg_pool_d;
      cfg_size_q   <= cfg_size_d;
      cfg_align_q  <= cfg_align_d;
      free_head_q  <= free_head_d;
      slot_count_q <= slot_count_d;
      adj_q        <= adj_d;
      used_q       <= used_d;
      live_q       <= live_d;
      prod_q       <= prod_d;
      link_idx_q   <= link_idx_d;
      div_quot_q   <= div_quot_d;
      div_rem_q    <= div_rem_d;
      div_cnt_q    <= div_cnt_d;
      init_take_q  <= init_take_d;
    end
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data_q <= link_mem[free_head_q[IDX_W-1:0]];
    end
  end

  // ---------------------------------------------------------------- checks
  // list head is a slot index or the null mark
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NIL_SLOT)
    else $error("free list head out of range");

  // slot count never exceeds the pool limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_count_q <= NIL_SLOT)
    else $error("slot count above pool limit");

  // a result word only appears after the sequencer finished an item
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result word without finished item");

  // link memory is written only by a push or the init sweep
  a_mem_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_FREE_FIN || state_q == ST_LINK))
    else $error("stray link memory write");

  // the divider runs only for free and init
  a_div_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (op_q == OP_FREE || op_q == OP_INIT))
    else $error("divider started for wrong operation");

endmodule
`default_nettype wire
